/* rtl/assert_macros.svh */
// assertion macros used by the union-find spanning weight unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, held off while rst_n is low
`define UFSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on clk, active during reset as well
`define UFSW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ufsw_pkg.sv */
// constants and types for the union-find spanning weight unit
`default_nettype none

package ufsw_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int VID_W        = $clog2(VERTEX_COUNT);
  localparam int RANK_W       = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;
  localparam int WEIGHT_W     = 32;
  localparam int SUM_W        = 64;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_FIND,
    ST_COMP,
    ST_LINK_RA,
    ST_LINK_RB,
    ST_LINK,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

/* rtl/union_find_spanning_weight_unit.sv */
// Union-find spanning weight unit: keeps a disjoint-set forest with path
// compression and union by rank over 1024 vertices and a running 64-bit sum
// of the weights of the edges that joined two sets. After reset the block
// runs a clearing pass over all 1024 entries of the parent and rank memories
// (every vertex its own root, rank zero) and holds in_ready low meanwhile.
// For each edge it then walks the parent links from each endpoint to its
// root, once for the search and again for the compression, one link per
// cycle on the single read port of the parent memory; when the edge joins
// two sets it then does two rank reads and the link write. The next edge is
// accepted once the result is loaded. Union by rank keeps these walks short.
// The result is held in an output register, so the next edge is accepted
// while a finished result still waits to be taken.
`default_nettype none

module union_find_spanning_weight_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [ufsw_pkg::VID_W-1:0]           in_vertex_a,
  input  wire logic [ufsw_pkg::VID_W-1:0]           in_vertex_b,
  input  wire logic signed [ufsw_pkg::WEIGHT_W-1:0] in_edge_weight,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_edge_taken,
  output logic signed [ufsw_pkg::SUM_W-1:0]         out_total_weight
);

  import ufsw_pkg::*;

  `include "assert_macros.svh"

  // forest memories
  logic [VID_W-1:0]  p_mem [VERTEX_COUNT];
  logic [RANK_W-1:0] k_mem [VERTEX_COUNT];

  logic [VID_W-1:0]  p_raddr, p_waddr, p_wdata, p_rdata_r;
  logic              p_we;
  logic [VID_W-1:0]  k_raddr, k_waddr;
  logic [RANK_W-1:0] k_wdata, k_rdata_r;
  logic              k_we;

  // sequencer state
  state_t                      state_r, state_nxt;
  logic [VID_W-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [VID_W-1:0]            cur_r, cur_nxt;
  logic [VID_W-1:0]            root_r, root_nxt;
  logic [VID_W-1:0]            ra_r, ra_nxt;
  logic                        side_r, side_nxt;
  logic [VID_W-1:0]            a_r, a_nxt;
  logic [VID_W-1:0]            b_r, b_nxt;
  logic signed [WEIGHT_W-1:0]  w_r, w_nxt;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic                        taken_r, taken_nxt;
  logic [RANK_W-1:0]           rank_a_r, rank_a_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_taken_r, out_taken_nxt;
  logic signed [SUM_W-1:0]     out_total_r, out_total_nxt;

  logic [VID_W-1:0] start_v;

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_edge_taken   = out_taken_r;
  assign out_total_weight = out_total_r;
  assign start_v          = side_r ? b_r : a_r;

  // parent memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
    p_rdata_r <= p_mem[p_raddr];
  end

  // rank memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (k_we) begin
      k_mem[k_waddr] <= k_wdata;
    end
    k_rdata_r <= k_mem[k_raddr];
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
    cur_r       <= cur_nxt;
    root_r      <= root_nxt;
    ra_r        <= ra_nxt;
    side_r      <= side_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    w_r         <= w_nxt;
    taken_r     <= taken_nxt;
    rank_a_r    <= rank_a_nxt;
    out_taken_r <= out_taken_nxt;
    out_total_r <= out_total_nxt;
  end

  // sequencer: clear, find, compress, link, report
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    side_nxt      = side_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    w_nxt         = w_r;
    sum_nxt       = sum_r;
    taken_nxt     = taken_r;
    rank_a_nxt    = rank_a_r;
    out_valid_nxt = out_valid_r;
    out_taken_nxt = out_taken_r;
    out_total_nxt = out_total_r;

    p_raddr = cur_r;
    p_we    = 1'b0;
    p_waddr = cur_r;
    p_wdata = root_r;
    k_raddr = ra_r;
    k_we    = 1'b0;
    k_waddr = root_r;
    k_wdata = '0;

    // result taken by the consumer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        // every vertex becomes its own root with rank zero
        p_we        = 1'b1;
        p_waddr     = clr_cnt_r;
        p_wdata     = clr_cnt_r;
        k_we        = 1'b1;
        k_waddr     = clr_cnt_r;
        k_wdata     = '0;
        clr_cnt_nxt = clr_cnt_r + VID_W'(1);
        if (clr_cnt_r == VID_W'(VERTEX_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        p_raddr = in_vertex_a;
        if (in_valid) begin
          a_nxt     = in_vertex_a;
          b_nxt     = in_vertex_b;
          w_nxt     = in_edge_weight;
          cur_nxt   = in_vertex_a;
          side_nxt  = 1'b0;
          taken_nxt = 1'b0;
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        // walk parent links, one per cycle, until a vertex points at itself
        if (p_rdata_r == cur_r) begin
          root_nxt  = cur_r;
          cur_nxt   = start_v;
          p_raddr   = start_v;
          state_nxt = ST_COMP;
        end else begin
          cur_nxt = p_rdata_r;
          p_raddr = p_rdata_r;
        end
      end
      ST_COMP: begin
        // second walk: point each visited vertex straight at the root
        if (cur_r == root_r) begin
          if (!side_r) begin
            ra_nxt    = root_r;
            side_nxt  = 1'b1;
            cur_nxt   = b_r;
            p_raddr   = b_r;
            state_nxt = ST_FIND;
          end else if (ra_r != root_r) begin
            state_nxt = ST_LINK_RA;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          p_we    = 1'b1;
          p_waddr = cur_r;
          p_wdata = root_r;
          cur_nxt = p_rdata_r;
          p_raddr = p_rdata_r;
        end
      end
      ST_LINK_RA: begin
        k_raddr   = ra_r;
        state_nxt = ST_LINK_RB;
      end
      ST_LINK_RB: begin
        k_raddr    = root_r;
        rank_a_nxt = k_rdata_r;
        state_nxt  = ST_LINK;
      end
      ST_LINK: begin
        // union by rank; a tie hangs the first root under the second
        p_we = 1'b1;
        if (rank_a_r > k_rdata_r) begin
          p_waddr = root_r;
          p_wdata = ra_r;
        end else begin
          p_waddr = ra_r;
          p_wdata = root_r;
          if (rank_a_r == k_rdata_r && k_rdata_r != RANK_MAX) begin
            k_we    = 1'b1;
            k_waddr = root_r;
            k_wdata = k_rdata_r + RANK_W'(1);
          end
        end
        sum_nxt   = sum_r + SUM_W'(w_r);
        taken_nxt = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_taken_nxt = taken_r;
          out_total_nxt = sum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outside the clearing pass no parent write makes a vertex its own root
  `UFSW_ASSERT(a_no_self_link, (p_we && state_r != ST_CLR) |-> (p_wdata != p_waddr), "self link written")

  // the total only moves in the link step
  `UFSW_ASSERT(a_sum_at_link, !$stable(sum_r) |-> $past(state_r == ST_LINK), "total changed outside link")

  // ranks are written only by the clearing pass and the link step
  `UFSW_ASSERT_ALWAYS(a_rank_write, k_we |-> (state_r == ST_LINK || state_r == ST_CLR), "stray rank write")

  // a link step is entered only for two different roots
  `UFSW_ASSERT(a_link_roots, (state_r == ST_LINK) |-> (ra_r != root_r), "link of one root")

endmodule

`default_nettype wire
